// File: rtl/frp_pkg.sv
package frp_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [9:0] CODE_MAX = 10'd999;
  localparam logic [2:0] NFIELDS  = 3'd6;

  localparam logic [9:0] PASSIVE_CODE_RST  = 10'd227;
  localparam logic [9:0] TRANSFER_CODE_RST = 10'd150;

  localparam int CODE_W = 10;
  localparam int TDATA_W = 96;

  // Configuration register indexes.
  localparam logic CFG_PASSIVE_CODE  = 1'b0;
  localparam logic CFG_TRANSFER_CODE = 1'b1;

  typedef struct packed {
    logic [9:0]      code_value;
    logic            code_done;
    logic            continuation;
    logic [7:0]      previous_byte;
    logic            in_parentheses;
    logic [31:0]     number_value;
    logic [2:0]      field_index;
    logic [5:0][7:0] address_fields;
    logic [1:0]      captured_flags;  // bit 0 address, bit 1 size
    logic [31:0]     captured_size;
  } parse_state_t;

  typedef struct packed {
    logic [9:0]  reply_code;
    logic [31:0] host_address;
    logic [15:0] data_port;
    logic        address_valid;
    logic [31:0] transfer_size;
    logic        size_valid;
    logic        ended_by_stream;
  } reply_res_t;

  typedef struct packed {
    logic [9:0] passive_code;
    logic [9:0] transfer_code;
  } cfg_codes_t;

endpackage

// File: rtl/frp_core.sv
module frp_core
  import frp_pkg::*;
(
  input  parse_state_t st,
  input  cfg_codes_t   cfg,
  input  logic [7:0]   rx_byte,
  input  logic         stream_end,
  output parse_state_t st_nxt,
  output logic         emit,
  output reply_res_t   res
);

  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] code_mul;
  logic [35:0] num_mul;
  logic [31:0] num_pushed;

  function automatic reply_res_t build_res(input parse_state_t s, input logic by_stream);
    reply_res_t r;
    r.reply_code      = s.code_value;
    r.host_address    = {s.address_fields[0], s.address_fields[1],
                         s.address_fields[2], s.address_fields[3]};
    r.data_port       = {s.address_fields[4], s.address_fields[5]};
    r.address_valid   = s.captured_flags[0];
    r.transfer_size   = s.captured_size;
    r.size_valid      = s.captured_flags[1];
    r.ended_by_stream = by_stream;
    return r;
  endfunction

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  // For an ASCII digit the low nibble is its value.
  assign digit    = rx_byte[3:0];
  assign code_mul = ({4'b0, st.code_value} << 3) + ({4'b0, st.code_value} << 1)
                    + {10'b0, digit};
  assign num_mul  = ({4'b0, st.number_value} << 3) + ({4'b0, st.number_value} << 1)
                    + {32'b0, digit};
  assign num_pushed = (num_mul[35:32] != 4'b0) ? 32'hFFFF_FFFF : num_mul[31:0];

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    res    = build_res(st, 1'b1);
    if (stream_end) begin
      emit   = 1'b1;
      st_nxt = '0;
    end else begin
      if (!st.code_done) begin
        if (is_digit) begin
          st_nxt.code_value = (code_mul > {4'b0, CODE_MAX}) ? CODE_MAX : code_mul[9:0];
        end else begin
          if (rx_byte == CH_DASH) begin
            st_nxt.continuation = 1'b1;
          end
          st_nxt.code_done = 1'b1;
        end
      end else if (st.code_value == cfg.passive_code) begin
        if (st.in_parentheses) begin
          if (rx_byte == CH_CLOSE || rx_byte == CH_COMMA) begin
            if (st.field_index < NFIELDS) begin
              st_nxt.address_fields[st.field_index] = st.number_value[7:0];
              st_nxt.field_index = st.field_index + 3'd1;
            end
            if (rx_byte == CH_CLOSE) begin
              st_nxt.in_parentheses    = 1'b0;
              st_nxt.captured_flags[0] = 1'b1;
            end else begin
              st_nxt.number_value = '0;
            end
          end else if (is_digit) begin
            st_nxt.number_value = num_pushed;
          end
        end else if (rx_byte == CH_OPEN) begin
          st_nxt.in_parentheses = 1'b1;
        end
      end else if (st.code_value == cfg.transfer_code) begin
        if (st.in_parentheses) begin
          if (rx_byte == CH_CLOSE) begin
            st_nxt.captured_size     = st.number_value;
            st_nxt.captured_flags[1] = 1'b1;
          end else if (is_digit) begin
            st_nxt.number_value = num_pushed;
          end
        end else if (rx_byte == CH_OPEN) begin
          st_nxt.in_parentheses = 1'b1;
        end
      end

      st_nxt.previous_byte = rx_byte;

      // End of line; the code may have been closed by this very byte.
      if (rx_byte == CH_LF && st.previous_byte == CH_CR && st_nxt.code_done) begin
        if (!st_nxt.continuation) begin
          emit   = 1'b1;
          res    = build_res(st_nxt, 1'b0);
          st_nxt = '0;
        end else begin
          st_nxt.code_done    = 1'b0;
          st_nxt.continuation = 1'b0;
          st_nxt.code_value   = '0;
        end
      end
    end
  end

endmodule

// File: rtl/frp_out_reg.sv
module frp_out_reg
  import frp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  reply_res_t           res,
  output logic                 slot_free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [TDATA_W-1:0]   out_tdata,
  output logic [0:0]           out_tuser
);

  logic       valid_r;
  logic       valid_nxt;
  reply_res_t res_r;

  assign slot_free = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0, res_r.size_valid, res_r.transfer_size, res_r.address_valid,
                       res_r.data_port, res_r.host_address, res_r.reply_code};
  assign out_tuser  = res_r.ended_by_stream;

endmodule

// File: rtl/ftp_reply_parser_top.sv
// Channel | Ports                    | Item
// in      | in_tvalid/tready/tdata/  | tdata: rx_byte[7:0]; tuser: stream_end
//         | in_tuser                 |
// out     | out_tvalid/tready/tdata/ | one reply result; tuser: ended_by_stream
//         | out_tuser                |
// cfg     | cfg_we/cfg_addr/cfg_wdata| 0 passive code, 1 transfer code
//
// One byte per cycle unless a reply-ending byte is held back: an accepted byte
// sits in the input register, the parse update runs on it there and the result
// register loads as the byte leaves the input register.
// Reset (synchronous, rst_n low) clears the parse state and both valids, and
// sets the codes to 227 and 150.
// A byte that ends a reply waits in the input register while the result
// register is full and not being taken; other bytes pass on regardless.
module ftp_reply_parser_top
  import frp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // rx_byte[7:0]
  input  logic [0:0]         in_tuser,   // stream_end[0]
  output logic               out_tvalid,
  input  logic               out_tready,
  // reply_code[9:0], host_address[41:10], data_port[57:42], address_valid[58],
  // transfer_size[90:59], size_valid[91], zero fill[95:92]
  output logic [TDATA_W-1:0] out_tdata,
  output logic [0:0]         out_tuser,  // ended_by_stream[0]
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [CODE_W-1:0]  cfg_wdata
);

  cfg_codes_t   cfg_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_end_r;
  logic         emit;
  reply_res_t   res;
  logic         slot_free;
  logic         s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.passive_code  <= PASSIVE_CODE_RST;
      cfg_r.transfer_code <= TRANSFER_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PASSIVE_CODE:  cfg_r.passive_code  <= cfg_wdata;
        CFG_TRANSFER_CODE: cfg_r.transfer_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_fire   = s1_valid_r && (!emit || slot_free);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      st_r       <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tuser[0];
    end
  end

  frp_core u_core (
    .st         (st_r),
    .cfg        (cfg_r),
    .rx_byte    (s1_byte_r),
    .stream_end (s1_end_r),
    .st_nxt     (st_nxt),
    .emit       (emit),
    .res        (res)
  );

  frp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_fire && emit),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && emit |=> st_r == '0)
    else $error("parse state not cleared after a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && !out_tready && s1_fire && emit))
    else $error("result register overwritten while held");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.code_value <= CODE_MAX)
    else $error("reply code above saturation limit");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.field_index <= NFIELDS)
    else $error("field index past last field");

endmodule

// File: sim/ftp_reply_parser_top_tb.sv
module ftp_reply_parser_top_tb;
  import frp_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTED     = 30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       stream_end;
  } rx_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_we;
  logic cfg_addr;
  logic [CODE_W-1:0] cfg_wdata;

  // Mirror of the code registers.
  logic [9:0] passive_code = PASSIVE_CODE_RST;
  logic [9:0] transfer_code = TRANSFER_CODE_RST;

  // Parse state of the reply in progress.
  logic [9:0]  code_acc;
  logic        code_ended;
  logic        cont_line;
  logic [7:0]  last_byte;
  logic        paren_open;
  logic [31:0] num_acc;
  logic [2:0]  field_count;
  logic [7:0]  octets [6];
  logic [1:0]  capture_flags;
  logic [31:0] byte_count;

  reply_res_t reply_q[$];
  rx_item_t   stim_q[$];

  int errors = 0;
  int items_sent = 0;
  int replies_checked = 0;
  int settings_written = 0;
  int cycle_count = 0;
  int rx_wait_left = 0;
  int hold_off_left = 0;
  bit rx_gaps_on = 1'b1;
  bit tx_gap_on = 1'b1;
  bit tx_gaps_enabled = 1'b1;
  string filler_chars = " .=abcdefghijklmnopqrstuvwxyzEPMOKT";

  ftp_reply_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic void reset_parse_state();
    code_acc = '0;
    code_ended = 1'b0;
    cont_line = 1'b0;
    last_byte = '0;
    paren_open = 1'b0;
    num_acc = '0;
    field_count = '0;
    foreach (octets[i]) octets[i] = '0;
    capture_flags = '0;
    byte_count = '0;
  endfunction

  function automatic void push_number_digit(input logic [7:0] b);
    logic [63:0] wide;
    wide = {32'd0, num_acc} * 64'd10 + {56'd0, b - CH_ZERO};
    num_acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  function automatic void store_octet();
    if (field_count < NFIELDS) begin
      octets[field_count] = num_acc[7:0];
      field_count++;
    end
  endfunction

  function automatic void queue_reply(input logic by_stream);
    reply_res_t r;
    r.reply_code      = code_acc;
    r.host_address    = {octets[0], octets[1], octets[2], octets[3]};
    r.data_port       = {octets[4], octets[5]};
    r.address_valid   = capture_flags[0];
    r.transfer_size   = byte_count;
    r.size_valid      = capture_flags[1];
    r.ended_by_stream = by_stream;
    reply_q.push_back(r);
  endfunction

  function automatic void parse_reply_byte(input rx_item_t it);
    int unsigned code_next;
    logic [7:0] b;
    b = it.rx_byte;
    if (it.stream_end) begin
      // The byte that travels with a stream end is stale and never parsed.
      queue_reply(1'b1);
      reset_parse_state();
      return;
    end
    if (!code_ended) begin
      if (is_digit(b)) begin
        code_next = int'(code_acc) * 10 + int'(b - CH_ZERO);
        code_acc = (code_next > CODE_MAX) ? CODE_MAX : 10'(code_next);
      end else begin
        if (b == CH_DASH) cont_line = 1'b1;
        code_ended = 1'b1;
      end
    end else if (code_acc == passive_code) begin
      if (paren_open) begin
        if (b == CH_CLOSE) begin
          paren_open = 1'b0;
          store_octet();
          capture_flags[0] = 1'b1;
        end else if (b == CH_COMMA) begin
          store_octet();
          num_acc = '0;
        end else if (is_digit(b)) begin
          push_number_digit(b);
        end
      end else if (b == CH_OPEN) begin
        paren_open = 1'b1;
      end
    end else if (code_acc == transfer_code) begin
      // A closing parenthesis captures the count but stays inside.
      if (paren_open) begin
        if (b == CH_CLOSE) begin
          byte_count = num_acc;
          capture_flags[1] = 1'b1;
        end else if (is_digit(b)) begin
          push_number_digit(b);
        end
      end else if (b == CH_OPEN) begin
        paren_open = 1'b1;
      end
    end
    if (b == CH_LF && last_byte == CH_CR && code_ended) begin
      code_ended = 1'b0;
      if (!cont_line) begin
        queue_reply(1'b0);
        reset_parse_state();
        return;
      end
      cont_line = 1'b0;
      code_acc = '0;
    end
    last_byte = b;
  endfunction

  // ---------------------------------------------------------- stimulus build

  function automatic void add_byte(input logic [7:0] b);
    rx_item_t it;
    it.rx_byte = b;
    it.stream_end = 1'b0;
    stim_q.push_back(it);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_decimal(input int unsigned v);
    add_text($sformatf("%0d", v));
  endfunction

  function automatic void add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic void add_stream_end();
    rx_item_t it;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.stream_end = 1'b1;
    stim_q.push_back(it);
  endfunction

  function automatic void add_code_digits(input logic [9:0] v);
    if ($urandom_range(0, 7) == 0) add_byte(CH_ZERO);
    add_decimal(v);
  endfunction

  // Mostly octet-sized values, some that need truncation and some long
  // digit strings that can overflow 32 bits.
  function automatic void add_field_number();
    case ($urandom_range(0, 9))
      7: add_decimal($urandom_range(256, 99999));
      8: repeat ($urandom_range(10, 14)) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      9: begin
        add_byte(CH_ZERO);
        add_decimal($urandom_range(0, 255));
      end
      default: add_decimal($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_filler();
    int r;
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 19);
      if (r == 0) add_byte(CH_CR);
      else if (r == 1) add_byte(CH_LF);
      else if (r < 5) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      else add_byte(filler_chars[$urandom_range(0, filler_chars.len() - 1)]);
    end
  endfunction

  function automatic void add_group();
    int n;
    add_byte(CH_OPEN);
    if ($urandom_range(0, 9) < 6) begin
      n = ($urandom_range(0, 3) != 0) ? 6 : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        if (i != 0) add_byte(CH_COMMA);
        add_field_number();
      end
      if ($urandom_range(0, 7) != 0) add_byte(CH_CLOSE);
    end else begin
      add_field_number();
      add_text(" bytes");
      add_byte(CH_CLOSE);
      if ($urandom_range(0, 3) == 0) begin
        add_field_number();
        add_byte(CH_CLOSE);
      end
    end
  endfunction

  function automatic void add_line(input bit continued);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_code_digits(passive_code);
      4, 5, 6:    add_code_digits(transfer_code);
      7:          add_decimal($urandom_range(0, 999));
      8:          ;
      default:    add_decimal($urandom_range(1000, 99999));
    endcase
    if (continued) add_byte(CH_DASH);
    else add_byte(($urandom_range(0, 7) == 0) ? CH_CR : CH_SPACE);
    add_filler();
    if ($urandom_range(0, 9) < 8) add_group();
    if ($urandom_range(0, 3) == 0) begin
      add_filler();
      add_group();
    end
    add_filler();
    if (continued || $urandom_range(0, 9) != 0) add_crlf();
    else add_stream_end();
  endfunction

  function automatic void build_reply();
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) add_line(1'b1);
    add_line(1'b0);
  endfunction

  // ----------------------------------------------------------- driving

  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 19)) : 0;
  endfunction

  task automatic send_item(input rx_item_t it);
    int gap;
    gap = tx_gap_on ? draw_wait() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.rx_byte;
    in_tuser  <= it.stream_end;
    do @(posedge clk); while (!in_tready);
    parse_reply_byte(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    // Bytes that end no reply may still sit in the pipeline.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_codes(input logic [9:0] passive, input logic [9:0] transfer);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PASSIVE_CODE;
    cfg_wdata <= passive;
    @(negedge clk);
    cfg_addr  <= CFG_TRANSFER_CODE;
    cfg_wdata <= transfer;
    @(negedge clk);
    cfg_we <= 1'b0;
    passive_code = passive;
    transfer_code = transfer;
    settings_written++;
  endtask

  task automatic send_replies(input int n_items, input bit with_pauses);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      build_reply();
      if (with_pauses && $urandom_range(0, 5) == 0) drain_results();
      tx_gap_on = tx_gaps_enabled && ($urandom_range(0, 3) != 0);
      sent += stim_q.size();
      send_queued();
    end
  endtask

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("reply %0d %s: got 0x%0h, expected 0x%0h",
                             replies_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    tx_gap_on = 1'b1;
    add_stream_end();          // stream end with nothing parsed yet
    add_text("9999");          // code saturates at 999
    add_crlf();
    add_text("227-(300,");     // continuation, octet truncated to 8 bits
    add_crlf();
    add_text("227 9)");        // parentheses carry over the continuation
    add_crlf();
    send_queued();
    drain_results();
  endtask

  task automatic test_reset_codes();
    send_replies(250, 1'b0);
    drain_results();
  endtask

  task automatic test_code_extremes();
    write_codes(10'd0, 10'd999);
    send_replies(200, 1'b0);
    drain_results();
    write_codes(10'd999, 10'd0);
    send_replies(200, 1'b0);
    drain_results();
  endtask

  task automatic test_equal_codes();
    logic [9:0] code;
    code = 10'($urandom_range(1, 998));
    write_codes(code, code);
    send_replies(150, 1'b0);
    drain_results();
  endtask

  task automatic test_noise();
    int r;
    write_codes(10'($urandom_range(0, 9)), 10'($urandom_range(0, 9)));
    tx_gap_on = 1'b1;
    repeat (200) begin
      r = $urandom_range(0, 19);
      case (r)
        0, 1, 2, 3, 4, 5: add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        6, 7:    add_byte(CH_CR);
        8, 9:    add_byte(CH_LF);
        10:      add_byte(CH_OPEN);
        11:      add_byte(CH_CLOSE);
        12:      add_byte(CH_COMMA);
        13:      add_byte(CH_DASH);
        14:      add_stream_end();
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
    send_queued();
    drain_results();
  endtask

  task automatic test_backpressure();
    write_codes(PASSIVE_CODE_RST, TRANSFER_CODE_RST);
    tx_gaps_enabled = 1'b0;
    hold_off_left = HOLD_OFF_CYCLES;
    send_replies(200, 1'b0);
    tx_gaps_enabled = 1'b1;
    drain_results();
  endtask

  task automatic test_drain_pause();
    write_codes(10'($urandom_range(100, 599)), 10'($urandom_range(600, 998)));
    send_replies(150, 1'b1);
    drain_results();
  endtask

  // ------------------------------------------------------------ processes

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_PASSIVE_CODE;
    cfg_wdata = '0;
    reset_parse_state();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_reset_codes();
    test_code_extremes();
    test_equal_codes();
    test_noise();
    test_backpressure();
    test_drain_pause();

    drain_results();
    if (reply_q.size() != 0)
      report_error($sformatf("%0d expected replies never arrived", reply_q.size()));
    $display("Sent %0d bytes and stream ends, checked %0d replies over %0d code settings,",
             items_sent, replies_checked, settings_written + 1);
    $display("with code extremes, equal codes, byte noise, a long hold-off and drains.");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Result side: random waits per item, plus a long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_tready <= 1'b0;
        hold_off_left--;
      end else if (rx_wait_left > 0) begin
        out_tready <= 1'b0;
        rx_wait_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    reply_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        report_error($sformatf("result 0x%0h arrived with no reply pending", out_tdata));
      end else begin
        want = reply_q.pop_front();
        check_field("reply_code", 32'(out_tdata[9:0]), 32'(want.reply_code));
        check_field("host_address", out_tdata[41:10], want.host_address);
        check_field("data_port", 32'(out_tdata[57:42]), 32'(want.data_port));
        check_field("address_valid", 32'(out_tdata[58]), 32'(want.address_valid));
        check_field("transfer_size", out_tdata[90:59], want.transfer_size);
        check_field("size_valid", 32'(out_tdata[91]), 32'(want.size_valid));
        check_field("zero fill", 32'(out_tdata[TDATA_W-1:92]), 32'd0);
        check_field("ended_by_stream", 32'(out_tuser[0]), 32'(want.ended_by_stream));
      end
      replies_checked++;
      if ($urandom_range(0, 15) == 0) rx_gaps_on = !rx_gaps_on;
      rx_wait_left = rx_gaps_on ? draw_wait() : 0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles.", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
